// ----- design/mrd_pkg.sv -----
// Shared event codes, packet type codes and result types for the MQTT receive deframer.
package mrd_pkg;

  // Event codes carried on event_res
  localparam logic [3:0] EV_TOPIC        = 4'd0;
  localparam logic [3:0] EV_PAYLOAD      = 4'd1;
  localparam logic [3:0] EV_PUB_END      = 4'd2;
  localparam logic [3:0] EV_PUBACK       = 4'd3;
  localparam logic [3:0] EV_CONNACK_OK   = 4'd4;
  localparam logic [3:0] EV_CONNACK_REF  = 4'd5;
  localparam logic [3:0] EV_SUBACK_REJ   = 4'd6;
  localparam logic [3:0] EV_SUBACK_SHORT = 4'd7;
  localparam logic [3:0] EV_LEN_ERR      = 4'd8;

  // Control packet types from the fixed header
  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam logic [3:0] TYPE_SUBACK  = 4'd9;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] packet_id;
    logic [7:0]  return_code;
    logic [15:0] topic_index;
    logic [1:0]  qos;
    logic [15:0] topic_length;
    logic        last;
  } result_t;

  // Up to two results from one received byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } parse_out_t;

endpackage

// ----- design/mrd_parser.sv -----
// Fixed header tracker and per-type body parser: one received byte per step.
module mrd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output mrd_pkg::parse_out_t res
);
  import mrd_pkg::*;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_LEN,
    PH_BODY,
    PH_DROP
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  packet_type, packet_type_next;
  logic [3:0]  packet_flags, packet_flags_next;
  logic [2:0]  length_byte_count, length_byte_count_next;
  logic [27:0] remaining_length, remaining_length_next;
  logic [27:0] body_position, body_position_next;
  logic [15:0] topic_len_reg, topic_len_reg_next;
  logic [15:0] packet_id_reg, packet_id_reg_next;
  logic [7:0]  first_body_byte, first_body_byte_next;

  logic        have_a, have_b;
  result_t     res_a, res_b;
  logic [27:0] len_group;
  logic        fin;
  logic        alive;
  logic [1:0]  qos_cur;
  logic [15:0] topic_len_new;
  logic [28:0] rl_ext;
  logic [28:0] tl_ext;
  logic [27:0] pos_m1;

  assign qos_cur = packet_flags[2:1];
  assign rl_ext  = {1'b0, remaining_length};
  assign tl_ext  = {13'd0, topic_len_reg};
  assign pos_m1  = body_position - 28'd1;

  // Next state and up to two results for the byte in hand
  always_comb begin
    phase_next             = phase;
    packet_type_next       = packet_type;
    packet_flags_next      = packet_flags;
    length_byte_count_next = length_byte_count;
    remaining_length_next  = remaining_length;
    body_position_next     = body_position;
    topic_len_reg_next     = topic_len_reg;
    packet_id_reg_next     = packet_id_reg;
    first_body_byte_next   = first_body_byte;
    have_a        = 1'b0;
    have_b        = 1'b0;
    res_a         = '0;
    res_b         = '0;
    len_group     = '0;
    fin           = 1'b0;
    alive         = 1'b1;
    topic_len_new = {first_body_byte, rx_byte};

    case (phase)
      PH_HDR: begin
        packet_type_next       = rx_byte[7:4];
        packet_flags_next      = rx_byte[3:0];
        length_byte_count_next = '0;
        remaining_length_next  = '0;
        body_position_next     = '0;
        topic_len_reg_next     = '0;
        packet_id_reg_next     = '0;
        first_body_byte_next   = '0;
        phase_next             = PH_LEN;
      end

      PH_LEN: begin
        // 7-bit group placed by its position in the length field
        case (length_byte_count[1:0])
          2'd0:    len_group = {21'd0, rx_byte[6:0]};
          2'd1:    len_group = {14'd0, rx_byte[6:0], 7'd0};
          2'd2:    len_group = {7'd0, rx_byte[6:0], 14'd0};
          default: len_group = {rx_byte[6:0], 21'd0};
        endcase
        remaining_length_next  = remaining_length | len_group;
        length_byte_count_next = length_byte_count + 3'd1;
        if (!rx_byte[7]) begin
          if (remaining_length_next == 28'd0) begin
            if (packet_type == TYPE_SUBACK) begin
              have_a = 1'b1;
              res_a.event_res = EV_SUBACK_SHORT;
            end
            phase_next = PH_HDR;
          end else begin
            phase_next = PH_BODY;
          end
        end else if (length_byte_count_next >= 3'd4) begin
          // continuation on the fourth length byte: resync on next byte
          have_a = 1'b1;
          res_a.event_res = EV_LEN_ERR;
          phase_next = PH_HDR;
        end
      end

      default: begin
        fin = ({1'b0, body_position} + 29'd1) >= rl_ext;
        body_position_next = body_position + 28'd1;
        if (phase == PH_BODY) begin
          case (packet_type)
            TYPE_CONNACK: begin
              if (body_position == 28'd1) first_body_byte_next = rx_byte;
              if (fin && body_position != 28'd0) begin
                have_a = 1'b1;
                if (first_body_byte_next == 8'd0) begin
                  res_a.event_res = EV_CONNACK_OK;
                end else begin
                  res_a.event_res   = EV_CONNACK_REF;
                  res_a.return_code = first_body_byte_next;
                end
              end
            end

            TYPE_PUBLISH: begin
              if (body_position == 28'd0) begin
                first_body_byte_next = rx_byte;
              end else if (body_position == 28'd1) begin
                topic_len_reg_next = topic_len_new;
                if (rl_ext < ({13'd0, topic_len_new} + 29'd2)) begin
                  // topic runs past the body: drop the rest quietly
                  alive = 1'b0;
                  if (!fin) phase_next = PH_DROP;
                end
              end else if ({1'b0, body_position} < tl_ext + 29'd2) begin
                have_a = 1'b1;
                res_a.event_res = EV_TOPIC;
                res_a.data_byte = rx_byte;
              end else if ((qos_cur != 2'd0) && (rl_ext >= tl_ext + 29'd4) &&
                           ({1'b0, body_position} < tl_ext + 29'd4)) begin
                // two packet id bytes follow the topic
                packet_id_reg_next = {packet_id_reg[7:0], rx_byte};
                if (({1'b0, body_position} == tl_ext + 29'd3) && (qos_cur == 2'd1)) begin
                  have_a = 1'b1;
                  res_a.event_res = EV_PUBACK;
                  res_a.packet_id = packet_id_reg_next;
                  res_a.qos       = qos_cur;
                end
              end else begin
                have_a = 1'b1;
                res_a.event_res = EV_PAYLOAD;
                res_a.data_byte = rx_byte;
              end
              if (fin && alive && body_position != 28'd0) begin
                have_b = 1'b1;
                res_b.event_res    = EV_PUB_END;
                res_b.packet_id    = packet_id_reg_next;
                res_b.qos          = qos_cur;
                res_b.topic_length = topic_len_reg_next;
              end
            end

            TYPE_SUBACK: begin
              if (body_position < 28'd2) begin
                packet_id_reg_next = {packet_id_reg[7:0], rx_byte};
              end else if (rx_byte == 8'h80) begin
                have_a = 1'b1;
                res_a.event_res   = EV_SUBACK_REJ;
                res_a.packet_id   = packet_id_reg;
                res_a.topic_index = (|pos_m1[27:16]) ? 16'hFFFF : pos_m1[15:0];
              end
              if (fin && remaining_length < 28'd3) begin
                have_a = 1'b1;
                res_a.event_res = EV_SUBACK_SHORT;
              end
            end

            default: ;
          endcase
        end
        if (fin) phase_next = PH_HDR;
      end
    endcase
  end

  // Pack results in order and mark the final one
  always_comb begin
    res = '0;
    if (have_a && have_b) begin
      res.count  = 2'd2;
      res.first  = res_a;
      res.second = res_b;
      res.second.last = 1'b1;
    end else if (have_a) begin
      res.count = 2'd1;
      res.first = res_a;
      res.first.last = 1'b1;
    end else if (have_b) begin
      res.count = 2'd1;
      res.first = res_b;
      res.first.last = 1'b1;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR;
      packet_type       <= '0;
      packet_flags      <= '0;
      length_byte_count <= '0;
      remaining_length  <= '0;
      body_position     <= '0;
      topic_len_reg     <= '0;
      packet_id_reg     <= '0;
      first_body_byte   <= '0;
    end else if (step) begin
      phase             <= phase_next;
      packet_type       <= packet_type_next;
      packet_flags      <= packet_flags_next;
      length_byte_count <= length_byte_count_next;
      remaining_length  <= remaining_length_next;
      body_position     <= body_position_next;
      topic_len_reg     <= topic_len_reg_next;
      packet_id_reg     <= packet_id_reg_next;
      first_body_byte   <= first_body_byte_next;
    end
  end

endmodule

// ----- design/mqtt_receive_deframer_unit.sv -----
// Top level of the MQTT receive deframer: input register, parser and result queue.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per beat.
//   Output channel (out_valid/out_ready) gives one event per beat with all
//   result fields; last marks the final event caused by a given byte.
//   A byte may cause zero, one or two events.
// Flow: an accepted byte waits in the input register and is parsed into the
//   result queue once two slots are free; its first event is offered from there.
// Throughput: one byte per cycle while the output keeps up; a byte with two
//   events holds the output for two beats. The four-entry result queue sets
//   this: a byte is parsed only when two queue slots are free.
// Reset: rst clears the parser to await a fixed header byte and empties the
//   input register and the result queue.
// Stall: when out_ready is low the queue fills, parsing pauses with the byte
//   held in the input register, and in_ready drops once that register is full.
module mqtt_receive_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_res,
  output logic [7:0]  data_byte,
  output logic [15:0] packet_id,
  output logic [7:0]  return_code,
  output logic [15:0] topic_index,
  output logic [1:0]  qos,
  output logic [15:0] topic_length,
  output logic        last
);
  import mrd_pkg::*;

  logic              in_full;
  logic [7:0]        in_byte;
  logic              step;
  logic              pop;
  parse_out_t        pres;
  result_t           queue [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr, wr_ptr;
  logic [QCNT_W-1:0] cnt, cnt_next;
  result_t           head;

  // Parse when a byte is held and two queue slots are free
  assign step     = in_full && (cnt <= QCNT_W'(QDEPTH - 2));
  assign in_ready = !in_full || step;
  assign pop      = out_valid && out_ready;
  assign cnt_next = cnt + QCNT_W'(pres.count) - QCNT_W'(pop);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) in_byte <= rx_byte;
  end

  mrd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .res     (pres)
  );

  // Result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (step) wr_ptr <= wr_ptr + QPTR_W'(pres.count);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      cnt <= step ? cnt_next : (cnt - QCNT_W'(pop));
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (step && pres.count != 2'd0) queue[wr_ptr] <= pres.first;
    if (step && pres.count == 2'd2) queue[wr_ptr + QPTR_W'(1)] <= pres.second;
  end

  assign head         = queue[rd_ptr];
  assign out_valid    = (cnt != '0);
  assign event_res    = head.event_res;
  assign data_byte    = head.data_byte;
  assign packet_id    = head.packet_id;
  assign return_code  = head.return_code;
  assign topic_index  = head.topic_index;
  assign qos          = head.qos;
  assign topic_length = head.topic_length;
  assign last         = head.last;

`ifndef SYNTHESIS
  // Queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  // A byte held without being parsed stays held
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !step) |=> in_full)
    else $error("held byte lost");

  // An event without last is always followed by another from the same byte
  a_last_chain: assert property (@(posedge clk) disable iff (rst)
    (pop && !last) |=> out_valid)
    else $error("event chain cut before last");

  // Parsing never pushes into a queue without room for two beats
  a_room: assert property (@(posedge clk) disable iff (rst)
    (step && pres.count != 2'd0) |-> (cnt <= QCNT_W'(QDEPTH - 2)))
    else $error("push without room");
`endif

endmodule
